>>> sv/decimal_text_to_fixed16_16_top_assert.svh
// Assertion macros for the decimal text to 16.16 fixed point block.
// Used by the top level; no other dependencies.
`ifndef DECIMAL_TEXT_TO_FIXED16_16_TOP_ASSERT_SVH
`define DECIMAL_TEXT_TO_FIXED16_16_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define DTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
// Next-cycle implication check.
`define DTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define DTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/dtf_pkg.sv
// Shared types, constants and functions for the decimal text parser.
// No dependencies.
package dtf_pkg;

    // Fixed point format and parse limits.
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 5;
    localparam int INT_W           = 16;
    localparam int FRAC_W          = 16;
    localparam int CNT_W           = 3;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 8;
    localparam int OUT_W           = 32;

    // Divider sizes: dividend is digit << FRAC_BITS, divisor up to 10^5.
    localparam int DIV_W     = FRAC_BITS + DIGIT_W;
    localparam int DVS_W     = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Character codes of the grammar.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

    // Parse phases.
    typedef enum logic [1:0] {
        PH_SIGN = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } ctl_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    // Status and result of the shared divider.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Power of ten for fraction position idx (0 is the first digit).
    function automatic logic [DVS_W-1:0] pow10(input logic [CNT_W-1:0] idx);
        logic [DVS_W-1:0] p;
        case (idx)
            3'd0:    p = 17'd10;
            3'd1:    p = 17'd100;
            3'd2:    p = 17'd1000;
            3'd3:    p = 17'd10000;
            3'd4:    p = 17'd100000;
            default: p = 17'd100000;
        endcase
        return p;
    endfunction

endpackage

>>> sv/dtf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on dtf_pkg.
module dtf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dtf_pkg::div_req_t req,
    output dtf_pkg::div_rsp_t rsp
);

    logic [dtf_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [dtf_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [dtf_pkg::DVS_W-1:0]     dvs_reg;
    logic [dtf_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [dtf_pkg::DVS_W:0]       trial;
    logic [dtf_pkg::DVS_W:0]       diff;
    logic                          fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial = {rem_reg, quo_reg[dtf_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Next values of the shift registers and the step counter.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[dtf_pkg::DVS_W-1:0] : trial[dtf_pkg::DVS_W-1:0];
            quo_next = {quo_reg[dtf_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + dtf_pkg::DIV_CNT_W'(1);
            if (cnt_reg == dtf_pkg::DIV_CNT_W'(dtf_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> sv/decimal_text_to_fixed16_16_top.sv
// Top level of the decimal text to signed 16.16 fixed point parser.
// Depends on dtf_pkg, dtf_div and decimal_text_to_fixed16_16_top_assert.svh.
//
// Usage:
// The input channel carries one ASCII character per transaction, with
// first_char marking the start of a string and last_char its end. The
// output channel carries one fixed_value transaction per string, sent
// after the character marked last. Both channels use valid and stall; a
// transaction completes on a clock edge with valid high and stall low.
// A sign, integer digit, point or ignored character needs no stall of its
// own. A fraction digit starts the shared iterative divider, which produces
// one quotient bit per cycle over 20 bits, and that character holds the
// input stalled until the division is done. After the last character the
// input stalls while the result moves into the output register, which
// happens once that register is free. The output register lets the next
// string's characters be taken while a result waits; only the next result
// waits for it to drain. A stalled result holds its value. Reset clears
// the parse state, the sequencer and the output valid; no result is lost
// or repeated across a stall.
`include "decimal_text_to_fixed16_16_top_assert.svh"

module decimal_text_to_fixed16_16_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dtf_pkg::CHAR_W-1:0]          char_code,
    input  logic                                first_char,
    input  logic                                last_char,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dtf_pkg::OUT_W-1:0]    fixed_value
);

    dtf_pkg::ctl_state_t             state_reg, state_next;
    dtf_pkg::phase_t                 phase_reg, phase_next;
    logic                            neg_reg, neg_next;
    logic [dtf_pkg::INT_W-1:0]       int_reg, int_next;
    logic [dtf_pkg::FRAC_W-1:0]      frac_reg, frac_next;
    logic [dtf_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            last_reg, last_next;
    logic                            out_valid_reg, out_valid_next;
    logic [dtf_pkg::OUT_W-1:0]       value_reg;

    dtf_pkg::div_req_t               div_req;
    dtf_pkg::div_rsp_t               div_rsp;

    logic                            accept;
    logic                            out_free;
    logic                            load_out;
    logic                            need_div;

    // Parse state after an optional clear by first_char.
    dtf_pkg::phase_t                 base_phase;
    logic                            base_neg;
    logic [dtf_pkg::INT_W-1:0]       base_int;
    logic [dtf_pkg::FRAC_W-1:0]      base_frac;
    logic [dtf_pkg::CNT_W-1:0]       base_cnt;
    logic                            is_digit;
    logic [dtf_pkg::DIGIT_W-1:0]     digit;
    logic [dtf_pkg::INT_W-1:0]       int_mac;
    logic [dtf_pkg::CNT_W-1:0]       cnt_inc;
    logic [dtf_pkg::OUT_W-1:0]       mag;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Character classification and the integer multiply-accumulate.
    always_comb
    begin
        base_phase = first_char ? dtf_pkg::PH_SIGN : phase_reg;
        base_neg   = first_char ? 1'b0 : neg_reg;
        base_int   = first_char ? '0 : int_reg;
        base_frac  = first_char ? '0 : frac_reg;
        base_cnt   = first_char ? '0 : cnt_reg;
        is_digit   = (char_code >= dtf_pkg::CHAR_ZERO) && (char_code <= dtf_pkg::CHAR_NINE);
        digit      = dtf_pkg::DIGIT_W'(char_code - dtf_pkg::CHAR_ZERO);
        int_mac    = dtf_pkg::INT_W'({base_int, 3'b000})
                   + dtf_pkg::INT_W'({base_int, 1'b0})
                   + dtf_pkg::INT_W'(digit);
        cnt_inc    = cnt_reg + dtf_pkg::CNT_W'(1);
        need_div   = (base_phase == dtf_pkg::PH_FRAC) && is_digit
                   && (base_cnt < dtf_pkg::CNT_W'(dtf_pkg::MAX_FRAC_DIGITS));
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (need_div)
                    begin
                        state_next = dtf_pkg::ST_DIV;
                    end
                    else if (last_char)
                    begin
                        state_next = dtf_pkg::ST_EMIT;
                    end
                end
            end
            dtf_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = last_reg ? dtf_pkg::ST_EMIT : dtf_pkg::ST_IDLE;
                end
            end
            dtf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = dtf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtf_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_stall         = 1'b1;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {digit, dtf_pkg::FRAC_BITS'(0)};
        div_req.divisor  = dtf_pkg::pow10(base_cnt);
        case (state_reg)
            dtf_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                div_req.start = in_valid && need_div;
            end
            dtf_pkg::ST_DIV:
            begin
                in_stall = 1'b1;
            end
            dtf_pkg::ST_EMIT:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Parse state updates for an accepted character, a finished division
    // and an emitted result.
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        if (accept)
        begin
            phase_next = base_phase;
            neg_next   = base_neg;
            int_next   = base_int;
            frac_next  = base_frac;
            cnt_next   = base_cnt;
            last_next  = last_char;
            case (base_phase)
                dtf_pkg::PH_SIGN:
                begin
                    if (char_code == dtf_pkg::CHAR_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = dtf_pkg::PH_INT;
                    end
                    else if (is_digit)
                    begin
                        int_next   = int_mac;
                        phase_next = dtf_pkg::PH_INT;
                    end
                    else if (char_code == dtf_pkg::CHAR_POINT)
                    begin
                        phase_next = dtf_pkg::PH_FRAC;
                    end
                    else
                    begin
                        phase_next = dtf_pkg::PH_STOP;
                    end
                end
                dtf_pkg::PH_INT:
                begin
                    if (is_digit)
                    begin
                        int_next = int_mac;
                    end
                    else if (char_code == dtf_pkg::CHAR_POINT)
                    begin
                        phase_next = dtf_pkg::PH_FRAC;
                    end
                    else
                    begin
                        phase_next = dtf_pkg::PH_STOP;
                    end
                end
                dtf_pkg::PH_FRAC:
                begin
                    // A digit within the cap goes to the divider; the rest stops.
                    if (!need_div)
                    begin
                        phase_next = dtf_pkg::PH_STOP;
                    end
                end
                default:
                begin
                    phase_next = base_phase;
                end
            endcase
        end
        else if ((state_reg == dtf_pkg::ST_DIV) && div_rsp.done)
        begin
            frac_next = frac_reg + div_rsp.quotient[dtf_pkg::FRAC_W-1:0];
            cnt_next  = cnt_inc;
            if (cnt_inc >= dtf_pkg::CNT_W'(dtf_pkg::MAX_FRAC_DIGITS))
            begin
                phase_next = dtf_pkg::PH_STOP;
            end
        end
        else if (load_out)
        begin
            phase_next = dtf_pkg::PH_SIGN;
            neg_next   = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            cnt_next   = '0;
        end
    end

    // Assemble the 16.16 magnitude; the sign is applied when the output register loads.
    always_comb
    begin
        mag = (dtf_pkg::OUT_W'(int_reg) << dtf_pkg::FRAC_BITS) | dtf_pkg::OUT_W'(frac_reg);
    end

    // Output valid holds until the transaction completes.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and parse registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtf_pkg::ST_IDLE;
            phase_reg     <= dtf_pkg::PH_SIGN;
            neg_reg       <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output data register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_reg <= neg_reg ? (~mag + dtf_pkg::OUT_W'(1)) : mag;
        end
    end

    // Shared divider for the fraction digit weights.
    dtf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid   = out_valid_reg;
    assign fixed_value = value_reg;

    // The divider only runs while the sequencer waits on it.
    `DTF_ASSERT_IMP(a_div_busy_in_div, clk, rst_n, div_rsp.busy || div_rsp.done, state_reg == dtf_pkg::ST_DIV)
    // A finished result clears the parse state.
    `DTF_ASSERT_NXT(a_clear_after_emit, clk, rst_n, load_out, (phase_reg == dtf_pkg::PH_SIGN) && (int_reg == '0) && (frac_reg == '0))
    // The fraction phase never holds a full digit count.
    `DTF_ASSERT_IMP(a_frac_cap, clk, rst_n, phase_reg == dtf_pkg::PH_FRAC, cnt_reg < dtf_pkg::CNT_W'(dtf_pkg::MAX_FRAC_DIGITS))
    // A result is loaded only into a free output register.
    `DTF_ASSERT_IMP(a_load_free, clk, rst_n, load_out, !out_valid_reg || !out_stall)

endmodule

>>> tb/tb.sv
// Self-checking testbench for the decimal text to signed 16.16 fixed point parser.
// Depends on dtf_pkg and decimal_text_to_fixed16_16_top; directed strings, then random
// numbers under random idling and stalls, each result checked against a built-in predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtf_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int WATCHDOG    = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;

    // Scoreboard: tracks the parse of each accepted character and holds the
    // fixed point values still owed by the block.
    class fixed_value_scoreboard;
        phase_t                   phase;
        bit                       negative;
        bit [INT_W-1:0]           int_part;
        bit [FRAC_W-1:0]          frac_part;
        bit [CNT_W-1:0]           frac_count;
        logic signed [OUT_W-1:0]  owed_values[$];
        int                       chars_seen;
        int                       values_checked;
        int                       errors;

        function new();
            clear_parse();
            chars_seen     = 0;
            values_checked = 0;
            errors         = 0;
        endfunction

        function void clear_parse();
            phase      = PH_SIGN;
            negative   = 1'b0;
            int_part   = '0;
            frac_part  = '0;
            frac_count = '0;
        endfunction

        // Ten to the power of the fraction digit position (position 1 for the first digit).
        function int unsigned decade(input int position);
            int unsigned p;
            p = 1;
            repeat (position) p = p * 10;
            return p;
        endfunction

        function void add_fraction_digit(input bit [3:0] digit);
            bit [31:0] share;
            share      = ({28'd0, digit} << FRAC_BITS) / decade(int'(frac_count) + 1);
            frac_part  = frac_part + share[FRAC_W-1:0];
            frac_count = frac_count + 1'b1;
            if (frac_count >= MAX_FRAC_DIGITS)
                phase = PH_STOP;
        endfunction

        function void parse_char(input bit [CHAR_W-1:0] c);
            bit       is_digit;
            bit [3:0] digit;
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            digit    = 4'(c - CHAR_ZERO);
            case (phase)
                PH_SIGN:
                begin
                    if (c == CHAR_MINUS)
                    begin
                        negative = 1'b1;
                        phase    = PH_INT;
                    end
                    else if (is_digit)
                    begin
                        int_part = int_part * 10 + digit;
                        phase    = PH_INT;
                    end
                    else if (c == CHAR_POINT)
                        phase = PH_FRAC;
                    else
                        phase = PH_STOP;
                end
                PH_INT:
                begin
                    if (is_digit)
                        int_part = int_part * 10 + digit;
                    else if (c == CHAR_POINT)
                        phase = PH_FRAC;
                    else
                        phase = PH_STOP;
                end
                PH_FRAC:
                begin
                    if (is_digit)
                        add_fraction_digit(digit);
                    else
                        phase = PH_STOP;
                end
                default:
                begin
                end
            endcase
        endfunction

        // Called for every accepted input transaction.
        function void note_char(input bit [CHAR_W-1:0] c, input bit first, input bit last);
            bit [OUT_W-1:0] value;
            chars_seen++;
            if (first)
                clear_parse();
            parse_char(c);
            if (last)
            begin
                value = {int_part, frac_part};
                if (negative)
                    value = -value;
                owed_values.push_back(signed'(value));
                clear_parse();
            end
        endfunction

        task report_mismatch(input string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Called for every accepted output transaction.
        task check_value(input logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (owed_values.size() == 0)
                report_mismatch($sformatf("fixed_value %h arrived with no string pending", got));
            else
            begin
                want = owed_values.pop_front();
                values_checked++;
                if (got !== want)
                    report_mismatch($sformatf("fixed_value got %h, want %h", got, want));
            end
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [CHAR_W-1:0]        char_code;
    logic                     first_char;
    logic                     last_char;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [OUT_W-1:0]  fixed_value;

    fixed_value_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int chars_sent;
    int strings_sent;
    int quiet_cycles;
    int hold_left;
    bit hold_req;
    bit hold_taken;

    decimal_text_to_fixed16_16_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .first_char  (first_char),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fixed_value (fixed_value)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result receiver: random stalls, or one long hold-off once it is requested.
    initial
    begin
        hold_left  = 0;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor of both channels, plus the watchdog on cycles with no transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            if (out_valid && !out_stall)
                sb.check_value(fixed_value);
            if (in_valid && !in_stall)
                sb.note_char(char_code, first_char, last_char);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG);
                $display("[decimal_text_to_fixed16_16_top] ERROR");
                $finish;
            end
        end
    end

    // Sends one string, one character per transaction, last_char on the final one.
    task automatic send_text(input byte unsigned text[$], input bit mark_first,
                             input bit allow_restart);
        for (int i = 0; i < text.size(); i++)
        begin
            bit first;
            first = (i == 0) ? mark_first : (allow_restart && ($urandom_range(99) < 2));
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid   <= 1'b1;
            char_code  <= text[i];
            first_char <= first;
            last_char  <= (i == text.size() - 1);
            do @(posedge clk); while (in_stall);
            chars_sent++;
        end
        strings_sent++;
    endtask

    task automatic send_str(input string s, input bit mark_first);
        byte unsigned text[$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text(text, mark_first, 1'b0);
    endtask

    // Mostly well-formed numbers with random digits; some noise and damaged text.
    function automatic void make_number(output byte unsigned text[$]);
        int n;
        int idx;
        text = {};
        if ($urandom_range(99) < 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n) text.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(2) == 0)
            text.push_back(CHAR_MINUS);
        n = ($urandom_range(9) == 0) ? 5 : $urandom_range(0, 3);
        repeat (n) text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
        if ($urandom_range(3) != 0)
        begin
            text.push_back(CHAR_POINT);
            n = $urandom_range(0, 7);
            repeat (n) text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
        end
        if (text.size() == 0)
            text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
        if ($urandom_range(99) < 10)
        begin
            idx = $urandom_range(text.size() - 1);
            case ($urandom_range(2))
                0:       text[idx] = 8'($urandom_range(255));
                1:       text.insert(idx, CHAR_MINUS);
                default: text.insert(idx, CHAR_POINT);
            endcase
        end
    endfunction

    task automatic run_random(input int count);
        byte unsigned text[$];
        int target;
        target = chars_sent + count;
        while (chars_sent < target)
        begin
            make_number(text);
            send_text(text, $urandom_range(9) != 0, 1'b1);
        end
    endtask

    // Main sequence.
    initial
    begin
        byte unsigned odd_byte[$];
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_code     = '0;
        first_char    = 1'b0;
        last_char     = 1'b0;
        hold_req      = 1'b0;
        chars_sent    = 0;
        strings_sent  = 0;
        send_idle_pct = 18;
        recv_idle_pct = 57;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fraction cap with a digit past it, second minus, bare point,
        // integer wrap sent without first_char right after a result, point straight
        // after the sign with a stop on a letter, and the all-ones and NUL bytes.
        send_str("9.999999", 1'b1);
        send_str("--7", 1'b1);
        send_str(".", 1'b1);
        send_str("70000", 1'b0);
        send_str("-.5x9", 1'b1);
        odd_byte = {8'hFF};
        send_text(odd_byte, 1'b1, 1'b0);
        odd_byte = {8'h00};
        send_text(odd_byte, 1'b1, 1'b0);

        // Random numbers under three idling mixes; the last one opens with a long
        // receiver hold-off so the output backs up into the input.
        run_random(500);
        send_idle_pct = 57;
        recv_idle_pct = 18;
        run_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_random(500);
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (sb.owed_values.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d characters in %0d strings; %0d fixed point results checked.",
                 sb.chars_seen, strings_sent, sb.values_checked);
        $display("Mismatches found: %0d.", sb.errors);
        if (sb.errors == 0)
            $display("[decimal_text_to_fixed16_16_top] OK");
        else
            $display("[decimal_text_to_fixed16_16_top] ERROR");
        $finish;
    end

endmodule
